@@ src/ptsch_pkg.sv @@
package ptsch_pkg;

	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_SCHED    = 3'd1;
	localparam logic [2:0] FN_ADD      = 3'd2;
	localparam logic [2:0] FN_KILL_ID  = 3'd3;
	localparam logic [2:0] FN_KILL_RUN = 3'd4;
	localparam logic [2:0] FN_SLEEP    = 3'd5;
	localparam logic [2:0] FN_EVENT    = 3'd6;
	localparam logic [2:0] FN_BLOCK    = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_LIMIT    = 2'd1;
	localparam logic [1:0] ST_LAST     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  prio;
		logic [31:0] entry;
		logic [31:0] target;
		logic [31:0] dur;
		logic [31:0] period;
		logic [31:0] start;
		logic [3:0]  slot;
		logic        bval;
	} cmd_t;

endpackage

@@ src/ptsch_in_if.sv @@
interface ptsch_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [7:0]  priority_req;
	logic [31:0] entry_address;
	logic [31:0] target_id;
	logic [31:0] duration;
	logic [31:0] period;
	logic [31:0] start_time;
	logic [3:0]  slot_index;
	logic        block_value;

	modport source (output valid, func, priority_req, entry_address, target_id, duration,
		period, start_time, slot_index, block_value, input ready);
	modport sink (input valid, func, priority_req, entry_address, target_id, duration,
		period, start_time, slot_index, block_value, output ready);
endinterface

@@ src/ptsch_out_if.sv @@
interface ptsch_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        fired;
	logic [2:0]  event_index;
	logic [31:0] handler_address;
	logic        next_valid;
	logic [3:0]  next_slot;
	logic [31:0] run_address;
	logic [31:0] current_id;
	logic [4:0]  thread_count;
	logic [31:0] new_id;
	logic        switch_request;
	logic        last;

	modport source (output valid, status, fired, event_index, handler_address, next_valid,
		next_slot, run_address, current_id, thread_count, new_id, switch_request, last,
		input ready);
	modport sink (input valid, status, fired, event_index, handler_address, next_valid,
		next_slot, run_address, current_id, thread_count, new_id, switch_request, last,
		output ready);
endinterface

@@ src/ptsch_front.sv @@
module ptsch_front (
	input  logic            clk,
	input  logic            arst_n,
	ptsch_in_if.sink        req,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output ptsch_pkg::cmd_t cmd
);

	ptsch_pkg::cmd_t fifo_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;
	ptsch_pkg::cmd_t in_cmd;

	always_comb begin
		in_cmd.func   = req.func;
		in_cmd.prio   = req.priority_req;
		in_cmd.entry  = req.entry_address;
		in_cmd.target = req.target_id;
		in_cmd.dur    = req.duration;
		in_cmd.period = req.period;
		in_cmd.start  = req.start_time;
		in_cmd.slot   = req.slot_index;
		in_cmd.bval   = req.block_value;
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ src/ptsch_back.sv @@
module ptsch_back #(
	parameter int THREAD_SLOTS = 16,
	parameter int EVENT_SLOTS  = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  ptsch_pkg::cmd_t cmd,
	ptsch_out_if.source     rsp
);

	localparam int SW  = $clog2(THREAD_SLOTS);
	localparam int CW  = $clog2(THREAD_SLOTS + 1);
	localparam int ECW = $clog2(EVENT_SLOTS + 1);
	localparam int EW  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DISP    = 4'd1;
	localparam logic [3:0] S_ADD2    = 4'd2;
	localparam logic [3:0] S_TW_RD   = 4'd3;
	localparam logic [3:0] S_TW_CHK  = 4'd4;
	localparam logic [3:0] S_TE_RD   = 4'd5;
	localparam logic [3:0] S_TE_CHK  = 4'd6;
	localparam logic [3:0] S_SW_RD   = 4'd7;
	localparam logic [3:0] S_SW_CHK  = 4'd8;
	localparam logic [3:0] S_SCH_END = 4'd9;
	localparam logic [3:0] S_KID_RD  = 4'd10;
	localparam logic [3:0] S_KID_CHK = 4'd11;
	localparam logic [3:0] S_KR_RD   = 4'd12;
	localparam logic [3:0] S_KR_UNL  = 4'd13;
	localparam logic [3:0] S_EMIT    = 4'd14;

	logic [3:0]        state_q;
	logic [3:0]        ret_q;
	ptsch_pkg::cmd_t   cmd_q;
	logic [31:0]       time_q;
	logic [THREAD_SLOTS-1:0] alive_q;
	logic [THREAD_SLOTS-1:0] asleep_q;
	logic [THREAD_SLOTS-1:0] blocked_q;
	logic [SW-1:0]     head_q;
	logic [SW-1:0]     tail_q;
	logic [CW-1:0]     live_q;
	logic [31:0]       ids_q;
	logic [SW-1:0]     rs_q;
	logic              rv_q;
	logic [31:0]       run_entry_q;
	logic [31:0]       run_ident_q;
	logic [ECW-1:0]    ecount_q;
	logic [CW-1:0]     i_q;
	logic [ECW-1:0]    j_q;
	logic [SW-1:0]     s_q;
	logic              found_q;
	logic [SW-1:0]     best_q;
	logic [7:0]        best_prio_q;
	logic [31:0]       best_entry_q;
	logic [31:0]       best_ident_q;

	logic [1:0]        res_status_q;
	logic              res_fired_q;
	logic [2:0]        res_evi_q;
	logic [31:0]       res_handler_q;
	logic [31:0]       res_newid_q;
	logic              res_sw_q;
	logic              res_last_q;

	logic              ov_q;
	logic [1:0]        o_status_q;
	logic              o_fired_q;
	logic [2:0]        o_evi_q;
	logic [31:0]       o_handler_q;
	logic              o_nv_q;
	logic [3:0]        o_slot_q;
	logic [31:0]       o_run_q;
	logic [31:0]       o_id_q;
	logic [4:0]        o_count_q;
	logic [31:0]       o_newid_q;
	logic              o_sw_q;
	logic              o_last_q;

	// thread and event tables
	logic [7:0]        prio_mem  [THREAD_SLOTS];
	logic [31:0]       ident_mem [THREAD_SLOTS];
	logic [31:0]       entry_mem [THREAD_SLOTS];
	logic [31:0]       wake_mem  [THREAD_SLOTS];
	logic [SW-1:0]     next_mem  [THREAD_SLOTS];
	logic [SW-1:0]     prev_mem  [THREAD_SLOTS];
	logic [31:0]       per_mem   [EVENT_SLOTS];
	logic [31:0]       due_mem   [EVENT_SLOTS];
	logic [31:0]       hnd_mem   [EVENT_SLOTS];

	logic [7:0]        rd_prio;
	logic [31:0]       rd_ident;
	logic [31:0]       rd_entry;
	logic [31:0]       rd_wake;
	logic [SW-1:0]     rd_next;
	logic [SW-1:0]     rd_prev;
	logic [31:0]       rd_per;
	logic [31:0]       rd_due;
	logic [31:0]       rd_hnd;

	logic [SW-1:0]     t_ra;
	logic [EW-1:0]     e_ra;
	logic [EW-1:0]     e_wr;
	logic [SW-1:0]     ti;
	logic [SW-1:0]     low_dead;
	logic [SW-1:0]     pick;
	logic [SW-1:0]     blk_idx;
	logic              blk_ok;
	logic              v_run;
	logic              is_add;
	logic              ev_add;
	logic              hit;
	logic              unl;
	logic              cand;
	logic              wake_due;
	logic              due_hit;
	logic              emit_go;

	logic              nx_we;
	logic [SW-1:0]     nx_wa;
	logic [SW-1:0]     nx_wd;
	logic              pv_we;
	logic [SW-1:0]     pv_wa;
	logic [SW-1:0]     pv_wd;
	logic              wk_we;
	logic [SW-1:0]     wk_wa;
	logic [31:0]       wk_wd;
	logic              du_we;
	logic [EW-1:0]     du_wa;
	logic [31:0]       du_wd;

	assign cmd_ready = (state_q == S_IDLE);
	assign ti        = i_q[SW-1:0];
	assign t_ra      = (state_q == S_TW_RD) ? ti : s_q;
	assign e_ra      = j_q[EW-1:0];
	assign e_wr      = ecount_q[EW-1:0];
	assign blk_idx   = SW'(cmd_q.slot);
	assign blk_ok    = (32'(cmd_q.slot) < 32'(THREAD_SLOTS));
	assign v_run     = rv_q && alive_q[rs_q];
	assign is_add    = (state_q == S_DISP) && (cmd_q.func == ptsch_pkg::FN_ADD)
		&& (live_q < CW'(THREAD_SLOTS));
	assign ev_add    = (state_q == S_DISP) && (cmd_q.func == ptsch_pkg::FN_EVENT)
		&& (ecount_q < ECW'(EVENT_SLOTS));
	assign hit       = alive_q[s_q] && (rd_ident == cmd_q.target);
	assign unl       = ((state_q == S_KID_CHK) && hit) || (state_q == S_KR_UNL);
	assign cand      = alive_q[s_q] && !blocked_q[s_q] && !asleep_q[s_q]
		&& (!found_q || (best_prio_q > rd_prio));
	assign wake_due  = (rd_wake <= time_q);
	assign due_hit   = (rd_due <= time_q);
	assign emit_go   = (state_q == S_EMIT) && (!ov_q || rsp.ready);

	// slot for a new thread
	always_comb begin
		low_dead = SW'(THREAD_SLOTS - 1);
		for (int k = THREAD_SLOTS - 2; k >= 0; k--) begin
			if (!alive_q[k]) begin
				low_dead = SW'(k);
			end
		end
		if ((ids_q < 32'(THREAD_SLOTS)) && !alive_q[SW'(ids_q)]) begin
			pick = SW'(ids_q);
		end else begin
			pick = low_dead;
		end
	end

	always_comb begin
		nx_we = 1'b0;
		nx_wa = s_q;
		nx_wd = s_q;
		pv_we = 1'b0;
		pv_wa = s_q;
		pv_wd = s_q;
		if (is_add) begin
			nx_we = 1'b1;
			nx_wa = pick;
			nx_wd = (live_q == '0) ? pick : head_q;
			pv_we = 1'b1;
			pv_wa = pick;
			pv_wd = (live_q == '0) ? pick : tail_q;
		end else if (state_q == S_ADD2) begin
			nx_we = 1'b1;
			nx_wa = tail_q;
			nx_wd = s_q;
			pv_we = 1'b1;
			pv_wa = head_q;
			pv_wd = s_q;
		end else if (unl) begin
			nx_we = 1'b1;
			nx_wa = rd_prev;
			nx_wd = rd_next;
			pv_we = 1'b1;
			pv_wa = rd_next;
			pv_wd = rd_prev;
		end
	end

	always_comb begin
		wk_we = 1'b0;
		wk_wa = rs_q;
		wk_wd = '0;
		if (is_add) begin
			wk_we = 1'b1;
			wk_wa = pick;
		end else if ((state_q == S_DISP) && (cmd_q.func == ptsch_pkg::FN_SLEEP) && v_run) begin
			wk_we = 1'b1;
			wk_wd = cmd_q.dur + time_q;
		end else if ((state_q == S_TW_CHK) && wake_due) begin
			wk_we = 1'b1;
			wk_wa = ti;
		end
	end

	always_comb begin
		du_we = 1'b0;
		du_wa = e_ra;
		du_wd = time_q + rd_per;
		if (ev_add) begin
			du_we = 1'b1;
			du_wa = e_wr;
			du_wd = cmd_q.start;
		end else if ((state_q == S_TE_CHK) && due_hit) begin
			du_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (is_add) begin
			prio_mem[pick]  <= cmd_q.prio;
			ident_mem[pick] <= ids_q;
			entry_mem[pick] <= cmd_q.entry;
		end
		rd_prio  <= prio_mem[t_ra];
		rd_ident <= ident_mem[t_ra];
		rd_entry <= entry_mem[t_ra];
	end

	always_ff @(posedge clk) begin
		if (wk_we) begin
			wake_mem[wk_wa] <= wk_wd;
		end
		rd_wake <= wake_mem[t_ra];
	end

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_wa] <= nx_wd;
		end
		rd_next <= next_mem[t_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_wa] <= pv_wd;
		end
		rd_prev <= prev_mem[t_ra];
	end

	always_ff @(posedge clk) begin
		if (ev_add) begin
			per_mem[e_wr] <= cmd_q.period;
			hnd_mem[e_wr] <= cmd_q.entry;
		end
		rd_per <= per_mem[e_ra];
		rd_hnd <= hnd_mem[e_ra];
	end

	always_ff @(posedge clk) begin
		if (du_we) begin
			due_mem[du_wa] <= du_wd;
		end
		rd_due <= due_mem[e_ra];
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q        <= 1'b0;
			o_status_q  <= '0;
			o_fired_q   <= 1'b0;
			o_evi_q     <= '0;
			o_handler_q <= '0;
			o_nv_q      <= 1'b0;
			o_slot_q    <= '0;
			o_run_q     <= '0;
			o_id_q      <= '0;
			o_count_q   <= '0;
			o_newid_q   <= '0;
			o_sw_q      <= 1'b0;
			o_last_q    <= 1'b0;
		end else begin
			if (emit_go) begin
				ov_q        <= 1'b1;
				o_status_q  <= res_status_q;
				o_fired_q   <= res_fired_q;
				o_evi_q     <= res_evi_q;
				o_handler_q <= res_handler_q;
				o_nv_q      <= v_run;
				o_slot_q    <= v_run ? 4'(rs_q) : 4'd0;
				o_run_q     <= v_run ? run_entry_q : 32'd0;
				o_id_q      <= v_run ? run_ident_q : 32'd0;
				o_count_q   <= 5'(live_q);
				o_newid_q   <= res_newid_q;
				o_sw_q      <= res_sw_q;
				o_last_q    <= res_last_q;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.status          = o_status_q;
	assign rsp.fired           = o_fired_q;
	assign rsp.event_index     = o_evi_q;
	assign rsp.handler_address = o_handler_q;
	assign rsp.next_valid      = o_nv_q;
	assign rsp.next_slot       = o_slot_q;
	assign rsp.run_address     = o_run_q;
	assign rsp.current_id      = o_id_q;
	assign rsp.thread_count    = o_count_q;
	assign rsp.new_id          = o_newid_q;
	assign rsp.switch_request  = o_sw_q;
	assign rsp.last            = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_IDLE;
			cmd_q         <= '0;
			time_q        <= '0;
			alive_q       <= '0;
			asleep_q      <= '0;
			blocked_q     <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			live_q        <= '0;
			ids_q         <= '0;
			rs_q          <= '0;
			rv_q          <= 1'b0;
			run_entry_q   <= '0;
			run_ident_q   <= '0;
			ecount_q      <= '0;
			i_q           <= '0;
			j_q           <= '0;
			s_q           <= '0;
			found_q       <= 1'b0;
			best_q        <= '0;
			best_prio_q   <= '0;
			best_entry_q  <= '0;
			best_ident_q  <= '0;
			res_status_q  <= ptsch_pkg::ST_OK;
			res_fired_q   <= 1'b0;
			res_evi_q     <= '0;
			res_handler_q <= '0;
			res_newid_q   <= '0;
			res_sw_q      <= 1'b0;
			res_last_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					res_status_q  <= ptsch_pkg::ST_OK;
					res_fired_q   <= 1'b0;
					res_evi_q     <= '0;
					res_handler_q <= '0;
					res_newid_q   <= '0;
					res_sw_q      <= 1'b0;
					res_last_q    <= 1'b1;
					ret_q         <= S_IDLE;
					state_q       <= S_EMIT;
					i_q           <= '0;
					j_q           <= '0;
					found_q       <= 1'b0;
					case (cmd_q.func)
						ptsch_pkg::FN_TICK: begin
							time_q  <= time_q + 32'd1;
							state_q <= S_TW_RD;
						end
						ptsch_pkg::FN_SCHED: begin
							s_q     <= v_run ? rs_q : head_q;
							state_q <= S_SW_RD;
						end
						ptsch_pkg::FN_ADD: begin
							if (!is_add) begin
								res_status_q <= ptsch_pkg::ST_LIMIT;
							end else begin
								s_q             <= pick;
								alive_q[pick]   <= 1'b1;
								asleep_q[pick]  <= 1'b0;
								blocked_q[pick] <= 1'b0;
								live_q          <= live_q + CW'(1);
								ids_q           <= ids_q + 32'd1;
								res_newid_q     <= ids_q;
								if (live_q == '0) begin
									head_q <= pick;
									tail_q <= pick;
								end else begin
									state_q <= S_ADD2;
								end
							end
						end
						ptsch_pkg::FN_KILL_ID: begin
							if (live_q <= CW'(1)) begin
								res_status_q <= ptsch_pkg::ST_LAST;
							end else begin
								s_q     <= head_q;
								state_q <= S_KID_RD;
							end
						end
						ptsch_pkg::FN_KILL_RUN: begin
							if (live_q <= CW'(1)) begin
								res_status_q <= ptsch_pkg::ST_LAST;
							end else if (!v_run) begin
								res_status_q <= ptsch_pkg::ST_NOTFOUND;
							end else begin
								s_q     <= rs_q;
								state_q <= S_KR_RD;
							end
						end
						ptsch_pkg::FN_SLEEP: begin
							if (v_run) begin
								asleep_q[rs_q] <= 1'b1;
							end
							res_sw_q <= 1'b1;
						end
						ptsch_pkg::FN_EVENT: begin
							if (ev_add) begin
								ecount_q <= ecount_q + ECW'(1);
							end else begin
								res_status_q <= ptsch_pkg::ST_LIMIT;
							end
						end
						default: begin
							if (blk_ok) begin
								blocked_q[blk_idx] <= cmd_q.bval;
							end
						end
					endcase
				end
				S_ADD2: begin
					tail_q  <= s_q;
					state_q <= S_EMIT;
				end
				S_TW_RD: begin
					if (i_q == CW'(THREAD_SLOTS)) begin
						state_q <= S_TE_RD;
					end else if (alive_q[ti] && asleep_q[ti]) begin
						state_q <= S_TW_CHK;
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				S_TW_CHK: begin
					if (wake_due) begin
						asleep_q[ti] <= 1'b0;
					end
					i_q     <= i_q + CW'(1);
					state_q <= S_TW_RD;
				end
				S_TE_RD: begin
					if (j_q == ecount_q) begin
						res_fired_q   <= 1'b0;
						res_evi_q     <= '0;
						res_handler_q <= '0;
						res_sw_q      <= 1'b1;
						res_last_q    <= 1'b1;
						ret_q         <= S_IDLE;
						state_q       <= S_EMIT;
					end else begin
						state_q <= S_TE_CHK;
					end
				end
				S_TE_CHK: begin
					j_q <= j_q + ECW'(1);
					if (due_hit) begin
						res_fired_q   <= 1'b1;
						res_evi_q     <= 3'(j_q);
						res_handler_q <= rd_hnd;
						res_sw_q      <= 1'b0;
						res_last_q    <= 1'b0;
						ret_q         <= S_TE_RD;
						state_q       <= S_EMIT;
					end else begin
						state_q <= S_TE_RD;
					end
				end
				S_SW_RD: begin
					if (i_q == live_q) begin
						state_q <= S_SCH_END;
					end else begin
						state_q <= S_SW_CHK;
					end
				end
				S_SW_CHK: begin
					if (cand) begin
						best_q       <= s_q;
						best_prio_q  <= rd_prio;
						best_entry_q <= rd_entry;
						best_ident_q <= rd_ident;
						found_q      <= 1'b1;
					end
					s_q     <= rd_next;
					i_q     <= i_q + CW'(1);
					state_q <= S_SW_RD;
				end
				S_SCH_END: begin
					rv_q <= found_q;
					if (found_q) begin
						rs_q        <= best_q;
						run_entry_q <= best_entry_q;
						run_ident_q <= best_ident_q;
					end
					state_q <= S_EMIT;
				end
				S_KID_RD: begin
					if (i_q == live_q) begin
						res_status_q <= ptsch_pkg::ST_NOTFOUND;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_KID_CHK;
					end
				end
				S_KID_CHK: begin
					if (hit) begin
						state_q <= S_EMIT;
					end else begin
						s_q     <= rd_next;
						i_q     <= i_q + CW'(1);
						state_q <= S_KID_RD;
					end
				end
				S_KR_RD: begin
					state_q <= S_KR_UNL;
				end
				S_KR_UNL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// unlink a killed thread from the ring
			if (unl) begin
				alive_q[s_q]   <= 1'b0;
				blocked_q[s_q] <= 1'b0;
				live_q         <= live_q - CW'(1);
				if (s_q == head_q) begin
					head_q <= rd_next;
				end
				if (s_q == tail_q) begin
					tail_q <= rd_prev;
				end
				if (rv_q && (rs_q == s_q)) begin
					rv_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ src/priority_thread_scheduler_core.sv @@
// channel  | dir | modport      | carries
// req      | in  | ptsch_in_if  | one operation beat (func and its arguments)
// rsp      | out | ptsch_out_if | result beats, last marks the final one of an operation
//
// one operation at a time in the back end; tick walks every thread slot, then every event,
// with a result beat per due event; schedule walks the ring for the ready thread with the
// lowest prio value; kill by id walks the ring for the id; the thread tables share one read address
// arst_n clears all control state and the live, asleep and blocked marks; no clearing pass
// a two-entry queue takes beats while the back end works; a full output register stalls it
module priority_thread_scheduler_core #(
	parameter int THREAD_SLOTS = 16,
	parameter int EVENT_SLOTS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ptsch_in_if.sink    req,
	ptsch_out_if.source rsp
);

	logic            cmd_valid;
	logic            cmd_ready;
	ptsch_pkg::cmd_t cmd;

	ptsch_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	ptsch_back #(
		.THREAD_SLOTS (THREAD_SLOTS),
		.EVENT_SLOTS  (EVENT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp       (rsp)
	);

endmodule
